// ----- rtl/hsvrgb_pkg.sv -----
`timescale 1ns / 1ps

package hsvrgb_pkg;

	// hue units: degrees * 256
	localparam logic [16:0] HUE_FULL  = 17'd92160;
	localparam logic [16:0] SEXTANT_W = 17'd15360;
	localparam logic [8:0]  Q8_ONE    = 9'd256;
	localparam logic [7:0]  CHAN_MAX  = 8'd255;

	// floor(n / 15) = (n * RECIP_15) >> RECIP_SHIFT for n < 2^20
	localparam logic [20:0] RECIP_15    = 21'd1118482;
	localparam int          RECIP_SHIFT = 24;

	// 60-degree sextants, named by the colours they run between
	typedef enum logic [2:0] {
		SX_R_Y = 3'd0,
		SX_Y_G = 3'd1,
		SX_G_C = 3'd2,
		SX_C_B = 3'd3,
		SX_B_M = 3'd4,
		SX_M_R = 3'd5
	} sextant_t;

endpackage

// ----- rtl/hsv_to_rgb_converter_unit.sv -----
`timescale 1ns / 1ps

// HSV to RGB colour converter, five-stage pipeline.
//
// Input stream (s_*): one request per pixel, hue in degrees * 256 (0..92159),
// saturation and value in Q8 (256 = 1.0). Hue from 92160 up to the field maximum of
// 131071 is wrapped once, saturation and value above 256 are clamped to 1.0.
// Output stream (m_*): 8-bit red, green and blue, truncated, saturated at 255.
//
// Throughput: one pixel per clock while m_tready is high. The stages, in order, are
// clamp -> chroma multiply -> ramp multiply -> reciprocal multiply (divide by
// 15360) -> channel scale into the output register.
//
// Each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up and the input keeps taking requests
// while a finished pixel waits in the output register. When the receiver
// drops m_tready the output holds, the stages fill up one by one, and
// s_tready falls only once every stage is occupied; nothing is lost or doubled.
//
// Reset (arst_n low) clears the valid bits only; the pipeline empties at once.

module hsv_to_rgb_converter_unit
	import hsvrgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // hue_q8[16:0], saturation[25:17], brightness_level[34:26]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

	logic [16:0] hue_in;
	logic [8:0]  sat_in;
	logic [8:0]  val_in;

	assign hue_in = s_tdata[16:0];
	assign sat_in = s_tdata[25:17];
	assign val_in = s_tdata[34:26];

	// valid bits and stage enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !vld_s5 || m_tready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= s_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: hue wrap, saturation / value clamp
	logic [16:0] h_s1;
	logic [8:0]  s_s1;
	logic [8:0]  v_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			h_s1 <= (hue_in >= HUE_FULL) ? hue_in - HUE_FULL : hue_in;
			s_s1 <= (sat_in > Q8_ONE) ? Q8_ONE : sat_in;
			v_s1 <= (val_in > Q8_ONE) ? Q8_ONE : val_in;
		end
	end

	// stage 2: sextant, ramp weight, chroma
	sextant_t    q_c;
	logic [16:0] base_c;
	logic [16:0] f_c;
	logic [16:0] t_c;

	always_comb begin
		if (h_s1 >= 17'(5 * SEXTANT_W)) begin
			q_c    = SX_M_R;
			base_c = 17'(5 * SEXTANT_W);
		end else if (h_s1 >= 17'(4 * SEXTANT_W)) begin
			q_c    = SX_B_M;
			base_c = 17'(4 * SEXTANT_W);
		end else if (h_s1 >= 17'(3 * SEXTANT_W)) begin
			q_c    = SX_C_B;
			base_c = 17'(3 * SEXTANT_W);
		end else if (h_s1 >= 17'(2 * SEXTANT_W)) begin
			q_c    = SX_G_C;
			base_c = 17'(2 * SEXTANT_W);
		end else if (h_s1 >= SEXTANT_W) begin
			q_c    = SX_Y_G;
			base_c = SEXTANT_W;
		end else begin
			q_c    = SX_R_Y;
			base_c = 17'd0;
		end
		f_c = h_s1 - base_c;
		// falling ramp in odd sextants
		t_c = q_c[0] ? SEXTANT_W - f_c : f_c;
	end

	sextant_t    q_s2;
	logic [13:0] t_s2;
	logic [16:0] c_s2;
	logic [8:0]  v_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			q_s2 <= q_c;
			t_s2 <= t_c[13:0];
			c_s2 <= 17'(s_s1) * 17'(v_s1);
			v_s2 <= v_s1;
		end
	end

	// stage 3: c * t, offset m = v*256 - c
	sextant_t    q_s3;
	logic [29:0] p_s3;
	logic [16:0] c_s3;
	logic [16:0] m_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			q_s3 <= q_s2;
			p_s3 <= 30'(c_s2) * 30'(t_s2);
			c_s3 <= c_s2;
			m_s3 <= {v_s2, 8'd0} - c_s2;
		end
	end

	// stage 4: x = p / 15360 = (p >> 10) / 15, by reciprocal
	logic [40:0] nm_c;

	assign nm_c = p_s3[29:10] * RECIP_15;

	sextant_t    q_s4;
	logic [16:0] x_s4;
	logic [16:0] c_s4;
	logic [16:0] m_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			q_s4 <= q_s3;
			x_s4 <= nm_c[RECIP_SHIFT +: 17];
			c_s4 <= c_s3;
			m_s4 <= m_s3;
		end
	end

	// stage 5: place c / x / 0, add m, scale by 255 into the output register
	logic [16:0] r_c, g_c, b_c;

	always_comb begin
		case (q_s4)
			SX_R_Y: begin r_c = c_s4;  g_c = x_s4;  b_c = '0;    end
			SX_Y_G: begin r_c = x_s4;  g_c = c_s4;  b_c = '0;    end
			SX_G_C: begin r_c = '0;    g_c = c_s4;  b_c = x_s4;  end
			SX_C_B: begin r_c = '0;    g_c = x_s4;  b_c = c_s4;  end
			SX_B_M: begin r_c = x_s4;  g_c = '0;    b_c = c_s4;  end
			default: begin r_c = c_s4; g_c = '0;    b_c = x_s4;  end
		endcase
	end

	function automatic logic [7:0] chan_scale(input logic [16:0] ch,
			input logic [16:0] m);
		logic [17:0] sum;
		logic [25:0] prod;
		logic [9:0]  y;
		sum  = {1'b0, ch} + {1'b0, m};
		prod = {sum, 8'd0} - {8'd0, sum};
		y    = prod[25:16];
		return (y > {2'b00, CHAN_MAX}) ? CHAN_MAX : y[7:0];
	endfunction

	logic [7:0] red_s5, green_s5, blue_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			red_s5   <= chan_scale(r_c, m_s4);
			green_s5 <= chan_scale(g_c, m_s4);
			blue_s5  <= chan_scale(b_c, m_s4);
		end
	end

	assign m_tvalid = vld_s5;
	assign m_tdata  = {blue_s5, green_s5, red_s5};

	// checks
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_tready)
		else $error("input stalled with stage 1 empty");

	a_ramp_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (t_s2 <= SEXTANT_W[13:0]))
		else $error("ramp weight beyond sextant width");

	a_sextant_code: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (q_s3 == $past(q_s2) || !$past(en3)))
		else $error("sextant lost between stages 2 and 3");

	a_ramp_below_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (x_s4 <= c_s4))
		else $error("ramp exceeds chroma");

	a_level_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> ({1'b0, c_s4} + {1'b0, m_s4} <= 18'd65536))
		else $error("chroma plus offset above full scale");

endmodule
